### rtl/utf8_validating_decoder_defines.svh
// Assertion macros shared by the UTF-8 decoder checker.
`ifndef UTF8_VALIDATING_DECODER_DEFINES_SVH
`define UTF8_VALIDATING_DECODER_DEFINES_SVH

// Same-cycle implication, ignored while reset is high.
`define U8D_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication check failed");

// Next-cycle implication, ignored while reset is high.
`define U8D_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

### rtl/u8d_pkg.sv
// Package with the types and constants of the UTF-8 validating decoder.
`timescale 1ns / 1ps

package u8d_pkg;

   // Result queue geometry.
   localparam int unsigned ResDepth = 4;
   localparam int unsigned ResPtrW  = $clog2(ResDepth);
   localparam int unsigned ResCntW  = $clog2(ResDepth + 1);

   // Codepoint constants.
   localparam logic [20:0] CP_REPL      = 21'h00FFFD;
   localparam logic [20:0] CP_SURR_LO   = 21'h00D800;
   localparam logic [20:0] CP_SURR_HI   = 21'h00DFFF;
   localparam logic [20:0] CP_MIN_2B    = 21'h000080;
   localparam logic [20:0] CP_MIN_3B    = 21'h000800;
   localparam logic [20:0] CP_MIN_4B    = 21'h010000;
   localparam logic [20:0] CP_MAX       = 21'h10FFFF;

   // Byte classification constants.
   localparam logic [7:0]  LEAD_MIN     = 8'hC2;
   localparam logic [7:0]  LEAD_MAX     = 8'hF4;
   localparam logic [7:0]  LEAD_3B      = 8'hE0;
   localparam logic [7:0]  LEAD_4B      = 8'hF0;
   localparam logic [1:0]  CONT_TAG     = 2'b10;

   // One decoded result as it sits in the result queue.
   typedef struct packed {
      logic [20:0] codepoint;
      logic [2:0]  bytes_used;
      logic        is_replacement;
      logic        string_end;
      logic        last_of_run;
   } result_type;

   // A completed sequence is rejected when overlong, a surrogate or out of range.
   function automatic logic cp_is_valid(input logic [20:0] cp, input logic [1:0] need);
      logic ok;
      ok = 1'b1;
      if (cp >= CP_SURR_LO && cp <= CP_SURR_HI) ok = 1'b0;
      if (cp < CP_MIN_2B) ok = 1'b0;
      if (need >= 2'd2 && cp < CP_MIN_3B) ok = 1'b0;
      if (need == 2'd3 && cp < CP_MIN_4B) ok = 1'b0;
      if (cp > CP_MAX) ok = 1'b0;
      return ok;
   endfunction

endpackage

### rtl/utf8_validating_decoder.sv
// Streaming UTF-8 validating decoder: one byte in, zero to two codepoints out.
//
// Usage: bytes arrive on the req_ channel (req_valid/req_ready, req_byte_in).
// Each accepted request is decoded in the cycle it is taken; the results it
// causes (none, one or two) are written into a four-entry result queue and
// leave on the rsp_ channel (rsp_valid/rsp_ready) one per cycle while
// rsp_ready is high. A result reaches the rsp_ ports from its queue entry.
// A request can be accepted in every cycle: the rate is one byte per cycle,
// set by the single decode stage, as long as the receiver takes results at
// least as fast as they are produced; a byte that gives two results (a cut
// sequence followed by a byte that stands alone, or a terminator behind a
// pending sequence) uses the single rsp_ port for both of them in turn.
// req_ready is high while the queue holds at most two results, so every
// accepted byte has room for both of its possible results. When the receiver
// stalls, results wait in the queue unchanged and req_ready drops once the
// queue holds more than two results. Synchronous reset empties the queue and
// returns the decoder to idle with no sequence pending.
`timescale 1ns / 1ps

module utf8_validating_decoder
   import u8d_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_byte_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [20:0] rsp_codepoint,
   output logic [2:0]  rsp_bytes_used,
   output logic        rsp_is_replacement,
   output logic        rsp_string_end,
   output logic        rsp_last_of_run
);

   // Decoder state.
   logic              active_ff, active_in;
   logic [1:0]        need_ff, need_in;
   logic [1:0]        have_ff, have_in;
   logic [20:0]       acc_ff, acc_in;

   // Result queue.
   result_type        res_ff [ResDepth];
   logic [ResPtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [ResPtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [ResCntW-1:0] count_ff, count_in;

   // Decode outputs.
   result_type        res0, res1;
   logic [1:0]        num_res;
   logic              push, pop;
   logic              is_cont;
   logic [20:0]       acc_shift;
   logic [2:0]        have_inc;
   logic [2:0]        used_cut;
   logic [1:0]        lead_need;
   logic [20:0]       lead_bits;
   logic [ResPtrW-1:0] wr_ptr_nxt;

   assign push      = req_valid && req_ready;
   assign pop       = rsp_valid && rsp_ready;
   assign is_cont   = (req_byte_in[7:6] == CONT_TAG);
   assign acc_shift = {acc_ff[14:0], req_byte_in[5:0]};
   assign have_inc  = {1'b0, have_ff} + 3'd1;
   assign used_cut  = {1'b0, have_ff} + 3'd1;

   // Lead byte class and its payload bits.
   always_comb begin
      priority if (req_byte_in < LEAD_3B) begin
         lead_need = 2'd1;
         lead_bits = {16'd0, req_byte_in[4:0]};
      end else if (req_byte_in < LEAD_4B) begin
         lead_need = 2'd2;
         lead_bits = {17'd0, req_byte_in[3:0]};
      end else begin
         lead_need = 2'd3;
         lead_bits = {18'd0, req_byte_in[2:0]};
      end
   end

   // Decode one byte against the pending sequence.
   always_comb begin
      active_in = active_ff;
      need_in   = need_ff;
      have_in   = have_ff;
      acc_in    = acc_ff;
      res0      = '0;
      res1      = '0;
      num_res   = 2'd0;

      priority if (req_byte_in == 8'd0) begin
         // Terminator flushes any pending sequence.
         active_in = 1'b0;
         need_in   = 2'd0;
         have_in   = 2'd0;
         acc_in    = '0;
         if (active_ff) begin
            res0    = '{CP_REPL, used_cut, 1'b1, 1'b0, 1'b0};
            res1    = '{21'd0, 3'd0, 1'b0, 1'b1, 1'b1};
            num_res = 2'd2;
         end else begin
            res0    = '{21'd0, 3'd0, 1'b0, 1'b1, 1'b1};
            num_res = 2'd1;
         end
      end else if (active_ff && is_cont) begin
         // Continuation byte extends the sequence.
         acc_in  = acc_shift;
         have_in = have_inc[1:0];
         if (have_inc >= {1'b0, need_ff}) begin
            active_in = 1'b0;
            need_in   = 2'd0;
            have_in   = 2'd0;
            acc_in    = '0;
            num_res   = 2'd1;
            if (cp_is_valid(acc_shift, need_ff)) begin
               res0 = '{acc_shift, {1'b0, need_ff} + 3'd1, 1'b0, 1'b0, 1'b1};
            end else begin
               res0 = '{CP_REPL, {1'b0, need_ff} + 3'd1, 1'b1, 1'b0, 1'b1};
            end
         end
      end else begin
         // A cut sequence is reported first, then the byte decodes from idle.
         if (active_ff) begin
            res0      = '{CP_REPL, used_cut, 1'b1, 1'b0, 1'b0};
            active_in = 1'b0;
            need_in   = 2'd0;
            have_in   = 2'd0;
            acc_in    = '0;
         end
         priority if (req_byte_in[7] == 1'b0) begin
            res1 = '{{13'd0, req_byte_in}, 3'd1, 1'b0, 1'b0, 1'b1};
         end else if (req_byte_in < LEAD_MIN || req_byte_in > LEAD_MAX) begin
            res1 = '{CP_REPL, 3'd1, 1'b1, 1'b0, 1'b1};
         end else begin
            active_in = 1'b1;
            need_in   = lead_need;
            have_in   = 2'd0;
            acc_in    = lead_bits;
         end
         // Pack the results into the lowest slots.
         if (active_ff) begin
            if (active_in) begin
               res0.last_of_run = 1'b1;
               num_res          = 2'd1;
            end else begin
               num_res = 2'd2;
            end
         end else if (!active_in) begin
            res0    = res1;
            num_res = 2'd1;
         end
      end
   end

   // Queue pointers and fill count.
   assign wr_ptr_nxt = wr_ptr_ff + ResPtrW'(1);
   always_comb begin
      rd_ptr_in = pop ? rd_ptr_ff + ResPtrW'(1) : rd_ptr_ff;
      wr_ptr_in = push ? wr_ptr_ff + ResPtrW'(num_res) : wr_ptr_ff;
      count_in  = count_ff + (push ? ResCntW'(num_res) : ResCntW'(0))
                  - (pop ? ResCntW'(1) : ResCntW'(0));
   end

   assign req_ready = (count_ff <= ResCntW'(ResDepth - 2));
   assign rsp_valid = (count_ff != '0);

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         need_ff   <= 2'd0;
         have_ff   <= 2'd0;
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
         if (push) begin
            active_ff <= active_in;
            need_ff   <= need_in;
            have_ff   <= have_in;
         end
      end
   end

   // Accumulator and queue entries.
   always_ff @(posedge clock) begin
      if (push) begin
         acc_ff <= acc_in;
         if (num_res != 2'd0) begin
            res_ff[wr_ptr_ff] <= res0;
         end
         if (num_res == 2'd2) begin
            res_ff[wr_ptr_nxt] <= res1;
         end
      end
   end

   // Head of the queue drives the response ports.
   assign rsp_codepoint      = res_ff[rd_ptr_ff].codepoint;
   assign rsp_bytes_used     = res_ff[rd_ptr_ff].bytes_used;
   assign rsp_is_replacement = res_ff[rd_ptr_ff].is_replacement;
   assign rsp_string_end     = res_ff[rd_ptr_ff].string_end;
   assign rsp_last_of_run    = res_ff[rd_ptr_ff].last_of_run;

endmodule

### rtl/u8d_checker.sv
// Port-level checker for the UTF-8 validating decoder, bound to the top level.
`timescale 1ns / 1ps
`include "utf8_validating_decoder_defines.svh"

module u8d_checker
   import u8d_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [7:0]  req_byte_in,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [20:0] rsp_codepoint,
   input logic [2:0]  rsp_bytes_used,
   input logic        rsp_is_replacement,
   input logic        rsp_string_end,
   input logic        rsp_last_of_run
);

   logic        cp_any;
   logic        end_shape_ok;
   logic        used_ok;
   logic        stalled;
   logic [23:0] rsp_head;

   assign cp_any = (rsp_codepoint <= CP_MAX) || (req_byte_in == 8'd0) || req_valid || req_ready;

   // Field shapes that the result ports must show.
   assign end_shape_ok = (rsp_codepoint == 21'd0) && (rsp_bytes_used == 3'd0)
                         && !rsp_is_replacement && rsp_last_of_run && cp_any;
   assign used_ok      = (rsp_bytes_used != 3'd0) && (rsp_bytes_used <= 3'd4)
                         && (rsp_codepoint <= CP_MAX);
   assign stalled      = rsp_valid && !rsp_ready;
   assign rsp_head     = {rsp_codepoint, rsp_bytes_used};

   // The terminator result carries no codepoint and closes its run.
   `U8D_ASSERT_IMPLY(a_end_shape, clock, reset, rsp_valid && rsp_string_end, end_shape_ok)

   // A replacement always carries U+FFFD.
   `U8D_ASSERT_IMPLY(a_repl_cp, clock, reset, rsp_valid && rsp_is_replacement, rsp_codepoint == CP_REPL)

   // Every other result used one to four bytes and stays in range.
   `U8D_ASSERT_IMPLY(a_used_range, clock, reset, rsp_valid && !rsp_string_end, used_ok)

   // A stalled result holds.
   `U8D_ASSERT_NEXT(a_rsp_hold, clock, reset, stalled, rsp_valid && $stable(rsp_head))

endmodule

bind utf8_validating_decoder u8d_checker u_u8d_checker (.*);
